// ===== src/vehicle_light_sequencer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the lamp sequencer
// Concurrent checks on clk; VLS_ASSERT is held off while rst is high, VLS_ASSERT_ALWAYS is not; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef VEHICLE_LIGHT_SEQUENCER_MACROS_SVH
`define VEHICLE_LIGHT_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define VLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vls assertion failed");
`define VLS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vls assertion failed");
`else
`define VLS_ASSERT(lbl, prop)
`define VLS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/vls_pkg.sv =====
// ---------------------------------------------------------------------------
// vls_pkg
// Shared types, codes and constants of the lamp sequencer.
// ---------------------------------------------------------------------------
package vls_pkg;

  localparam int PACKET_LEN = 6;
  localparam int BEAT_W     = $clog2(PACKET_LEN);

  // event kinds
  localparam logic [1:0] FUNC_SCAN   = 2'd0;
  localparam logic [1:0] FUNC_STROBE = 2'd1;
  localparam logic [1:0] FUNC_BLINK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BUS_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_STROBE_DUR  = 2'd1;
  localparam logic [1:0] CFG_BLINK_MODE  = 2'd2;
  localparam logic [1:0] CFG_DUAL_BEAM   = 2'd3;

  // reset values
  localparam logic [7:0] RST_BUS_ADDRESS = 8'hCC;
  localparam logic [7:0] RST_STROBE_DUR  = 8'd128;
  localparam logic [7:0] RST_PORT_IMAGE  = 8'h04;

  // headlight level thresholds
  localparam logic [7:0] LVL_DARK_LO = 8'd5;
  localparam logic [7:0] LVL_DARK_HI = 8'd30;
  localparam logic [7:0] LVL_MID_LO  = 8'd60;
  localparam logic [7:0] LVL_MID_HI  = 8'd100;
  localparam logic [7:0] LVL_DAY_HI  = 8'd150;

  // port image masks
  localparam logic [7:0] BEAM_KEEP   = 8'hE3;
  localparam logic [7:0] STROBE_BIT  = 8'h20;
  localparam logic [7:0] TURN_BITS   = 8'hC0;
  localparam logic [7:0] TURN_LEFT   = 8'h80;
  localparam logic [7:0] TURN_RIGHT  = 8'h40;
  localparam logic [7:0] PKT_FILL    = 8'hFF;

  typedef struct packed {
    logic [7:0] bus_address;
    logic [7:0] strobe_duration;
    logic       strobe_blink_mode;
    logic       dual_beam_mode;
  } vls_cfg_t;

  // outcome of one event, handed to the packet stage
  typedef struct packed {
    logic [7:0] port_value;
    logic       send;
  } vls_event_t;

endpackage

// ===== src/vehicle_light_sequencer.sv =====
// ---------------------------------------------------------------------------
// vehicle_light_sequencer
// Lamp controller: scan, strobe and blink events update the port image;
// a changed image after a scan goes out as a six-byte packet.
// ---------------------------------------------------------------------------
//  channel   direction  tdata / payload                     tuser     tlast
//  s_axis    in         buttons[3:0], adc_level[11:4]       func      -
//  m_axis    out        port_value[7:0], tx_byte[15:8]      tx_valid  last
//  cfg       in         cfg_index (register), cfg_data      -         -
//
//  An event is registered on transfer and evaluated in one pass when the packer takes it.
//  Non-changing events give one beat each, one per cycle back to back while
//  m_axis_tready stays high; a change packet holds the output register for six beats.
//  Stalls on m_axis fill the input register, then drop s_axis_tready.
//  rst is synchronous; config and lamp state return to their reset values.
// ---------------------------------------------------------------------------
`include "vehicle_light_sequencer_macros.svh"

module vehicle_light_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // buttons[3:0], adc_level[11:4], zero[15:12]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // port_value[7:0], tx_byte[15:8]
  output logic        m_axis_tuser,   // tx_valid
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  vls_pkg::vls_cfg_t   cfg;
  vls_pkg::vls_event_t ev;

  logic       in_valid;
  logic [1:0] in_func;
  logic [3:0] in_buttons;
  logic [7:0] in_level;
  logic       load_ready;
  logic       issue;
  logic       pkt_tail;

  assign cfg_ready     = 1'b1;
  assign issue         = in_valid && load_ready;
  assign s_axis_tready = !in_valid || load_ready;
  assign pkt_tail      = m_axis_tvalid && m_axis_tuser && m_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_address       <= vls_pkg::RST_BUS_ADDRESS;
      cfg.strobe_duration   <= vls_pkg::RST_STROBE_DUR;
      cfg.strobe_blink_mode <= 1'b1;
      cfg.dual_beam_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vls_pkg::CFG_BUS_ADDRESS: cfg.bus_address       <= cfg_data;
        vls_pkg::CFG_STROBE_DUR:  cfg.strobe_duration   <= cfg_data;
        vls_pkg::CFG_BLINK_MODE:  cfg.strobe_blink_mode <= cfg_data[0];
        vls_pkg::CFG_DUAL_BEAM:   cfg.dual_beam_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (issue) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func    <= s_axis_tuser;
      in_buttons <= s_axis_tdata[3:0];
      in_level   <= s_axis_tdata[11:4];
    end
  end

  vls_core u_core (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .func      (in_func),
    .buttons   (in_buttons),
    .adc_level (in_level),
    .cfg       (cfg),
    .ev        (ev)
  );

  vls_packer u_packer (
    .clk           (clk),
    .rst           (rst),
    .load          (in_valid),
    .ev            (ev),
    .bus_address   (cfg.bus_address),
    .load_ready    (load_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a beat without a packet byte is always the single result of its event
  `VLS_ASSERT(a_status_beat_last, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
  // the closing byte of a packet is fill
  `VLS_ASSERT(a_packet_tail_fill, pkt_tail |-> (m_axis_tdata[15:8] == vls_pkg::PKT_FILL))
  // a held event is not lost while the output stalls
  `VLS_ASSERT(a_input_held, (in_valid && !load_ready) |=> in_valid)
  // reset leaves nothing pending on either side
  `VLS_ASSERT_ALWAYS(a_reset_empty, rst |=> (!in_valid && !m_axis_tvalid))

endmodule

// ===== src/vls_core.sv =====
// ---------------------------------------------------------------------------
// vls_core
// Lamp state registers and the single-pass event logic for scan, strobe
// tick and blink tick.
// ---------------------------------------------------------------------------
module vls_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                issue,
  input  logic [1:0]          func,
  input  logic [3:0]          buttons,
  input  logic [7:0]          adc_level,
  input  vls_pkg::vls_cfg_t   cfg,
  output vls_pkg::vls_event_t ev
);

  logic [7:0] port_image, port_image_next;
  logic [7:0] last_sent, last_sent_next;
  logic [7:0] strobe_ticks, strobe_ticks_next;
  logic [1:0] turn_request, turn_request_next;
  logic       blink_phase, blink_phase_next;
  logic [1:0] headlight_key, headlight_key_next;

  logic [8:0] d9, h9, q9, e9, s9, qhe9, hq9, qe9, c9;

  always_comb begin
    d9   = {1'b0, cfg.strobe_duration};
    h9   = d9 >> 1;
    q9   = d9 >> 2;
    e9   = d9 >> 3;
    s9   = d9 >> 4;
    qhe9 = q9 + h9 + e9;
    hq9  = h9 + q9;
    qe9  = q9 + e9;
  end

  always_comb begin
    port_image_next    = port_image;
    last_sent_next     = last_sent;
    strobe_ticks_next  = strobe_ticks;
    turn_request_next  = turn_request;
    blink_phase_next   = blink_phase;
    headlight_key_next = headlight_key;
    c9                 = 9'd0;

    case (func)
      vls_pkg::FUNC_SCAN: begin
        case (buttons[2:0])
          3'b110:  turn_request_next = turn_request | 2'b01;
          3'b101:  turn_request_next = 2'b00;
          3'b011:  turn_request_next = turn_request | 2'b10;
          default: turn_request_next = turn_request;
        endcase
        if (!buttons[3]) strobe_ticks_next = 8'd1;

        if (adc_level < vls_pkg::LVL_DARK_HI && adc_level > vls_pkg::LVL_DARK_LO)
          headlight_key_next = 2'd1;
        if (adc_level < vls_pkg::LVL_MID_HI && adc_level > vls_pkg::LVL_MID_LO)
          headlight_key_next = 2'd2;
        if (adc_level < vls_pkg::LVL_DAY_HI && adc_level > vls_pkg::LVL_MID_HI)
          headlight_key_next = 2'd3;
        if (adc_level > vls_pkg::LVL_DAY_HI)
          headlight_key_next = 2'd0;

        case (headlight_key_next)
          2'd1: port_image_next = (port_image & vls_pkg::BEAM_KEEP) |
                                  (cfg.dual_beam_mode ? 8'h08 : 8'h18);
          2'd2: port_image_next = (port_image & vls_pkg::BEAM_KEEP) |
                                  (cfg.dual_beam_mode ? 8'h10 : 8'h08);
          2'd3: port_image_next = (port_image & vls_pkg::BEAM_KEEP) | 8'h04;
          default: port_image_next = port_image;
        endcase
      end

      vls_pkg::FUNC_STROBE: begin
        if (!cfg.strobe_blink_mode) begin
          if (strobe_ticks != 8'd0) begin
            strobe_ticks_next = strobe_ticks + 8'd1;
            port_image_next   = port_image | vls_pkg::STROBE_BIT;
          end else begin
            port_image_next   = port_image & ~vls_pkg::STROBE_BIT;
          end
        end else if (strobe_ticks != 8'd0) begin
          strobe_ticks_next = strobe_ticks + 8'd1;
          c9 = {1'b0, strobe_ticks_next};
          // strict bands; a count on a boundary keeps the lamp as it is
          if (c9 < d9   && c9 > qhe9) port_image_next = port_image & ~vls_pkg::STROBE_BIT;
          if (c9 < qhe9 && c9 > hq9)  port_image_next = port_image | vls_pkg::STROBE_BIT;
          if (c9 < hq9  && c9 > h9)   port_image_next = port_image & ~vls_pkg::STROBE_BIT;
          if (c9 < h9   && c9 > qe9)  port_image_next = port_image | vls_pkg::STROBE_BIT;
          if (c9 < qe9  && c9 > q9)   port_image_next = port_image & ~vls_pkg::STROBE_BIT;
          if (c9 < q9   && c9 > e9)   port_image_next = port_image | vls_pkg::STROBE_BIT;
          if (c9 < e9   && c9 > s9)   port_image_next = port_image & ~vls_pkg::STROBE_BIT;
          if (c9 < s9)                port_image_next = port_image | vls_pkg::STROBE_BIT;
          if (c9 > d9) begin
            strobe_ticks_next = 8'd0;
            port_image_next   = port_image & ~vls_pkg::STROBE_BIT;
          end
        end
        if (strobe_ticks_next > cfg.strobe_duration) strobe_ticks_next = 8'd0;
      end

      vls_pkg::FUNC_BLINK: begin
        if (!blink_phase) begin
          case (turn_request)
            2'd1:    port_image_next = port_image | vls_pkg::TURN_LEFT;
            2'd2:    port_image_next = port_image | vls_pkg::TURN_RIGHT;
            2'd3:    port_image_next = port_image | vls_pkg::TURN_BITS;
            default: port_image_next = port_image & ~vls_pkg::TURN_BITS;
          endcase
        end else begin
          case (turn_request)
            2'd1:    port_image_next = port_image & ~vls_pkg::TURN_LEFT;
            2'd2:    port_image_next = port_image & ~vls_pkg::TURN_RIGHT;
            default: port_image_next = port_image & ~vls_pkg::TURN_BITS;
          endcase
        end
        blink_phase_next = ~blink_phase;
      end

      default: ;
    endcase

    ev.port_value = port_image_next;
    ev.send       = (func == vls_pkg::FUNC_SCAN) && (port_image_next != last_sent);
    if (ev.send) last_sent_next = port_image_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_image    <= vls_pkg::RST_PORT_IMAGE;
      last_sent     <= 8'd0;
      strobe_ticks  <= 8'd0;
      turn_request  <= 2'd0;
      blink_phase   <= 1'b0;
      headlight_key <= 2'd0;
    end else if (issue) begin
      port_image    <= port_image_next;
      last_sent     <= last_sent_next;
      strobe_ticks  <= strobe_ticks_next;
      turn_request  <= turn_request_next;
      blink_phase   <= blink_phase_next;
      headlight_key <= headlight_key_next;
    end
  end

endmodule

// ===== src/vls_packer.sv =====
// ---------------------------------------------------------------------------
// vls_packer
// Result register: one status beat, or a six-byte change packet.
// ---------------------------------------------------------------------------
module vls_packer (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  vls_pkg::vls_event_t ev,
  input  logic [7:0]          bus_address,
  output logic                load_ready,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // port_value[7:0], tx_byte[15:8]
  output logic                m_axis_tuser,   // tx_valid
  output logic                m_axis_tlast
);

  localparam logic [vls_pkg::BEAT_W-1:0] BEAT_LAST = vls_pkg::BEAT_W'(vls_pkg::PACKET_LEN - 1);

  logic                      busy;
  logic                      send;
  logic [7:0]                port_value;
  logic [7:0]                address;
  logic [vls_pkg::BEAT_W-1:0] beat;
  logic [7:0]                tx_byte;
  logic                      at_end;

  assign at_end     = !send || (beat == BEAT_LAST);
  assign load_ready = !busy || (m_axis_tready && at_end);

  always_comb begin
    case (beat)
      vls_pkg::BEAT_W'(0): tx_byte = address;
      vls_pkg::BEAT_W'(1): tx_byte = ~address;
      vls_pkg::BEAT_W'(2): tx_byte = port_value;
      vls_pkg::BEAT_W'(3): tx_byte = ~port_value;
      default:             tx_byte = vls_pkg::PKT_FILL;
    endcase
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tuser  = send;
  assign m_axis_tlast  = at_end;
  assign m_axis_tdata  = {send ? tx_byte : 8'd0, port_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      send <= 1'b0;
      beat <= '0;
    end else if (load && load_ready) begin
      busy <= 1'b1;
      send <= ev.send;
      beat <= '0;
    end else if (busy && m_axis_tready) begin
      if (at_end) busy <= 1'b0;
      else        beat <= beat + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      port_value <= ev.port_value;
      address    <= bus_address;
    end
  end

endmodule
